// ----- design/bsw_pkg.sv -----
package bsw_pkg;

  // operation codes on in_func
  localparam logic [2:0] FUNC_BYTE    = 3'd0;
  localparam logic [2:0] FUNC_HALF    = 3'd1;
  localparam logic [2:0] FUNC_WORD    = 3'd2;
  localparam logic [2:0] FUNC_LEB     = 3'd3;
  localparam logic [2:0] FUNC_RESTART = 3'd4;

  // register index, taken from the word address
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [31:0] CAPACITY_RESET = 32'hffff_ffff;

  typedef enum logic [1:0] {
    K_FIXED,
    K_LEB,
    K_RESTART,
    K_NOP
  } kind_t;

  // classified command between front and back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  nbytes;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       overflow;
  } res_t;

endpackage

// ----- design/bsw_fifo.sv -----
module bsw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  // depth must be a power of two, at least two
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r;
  logic [AW:0]      rd_ptr_r;
  logic             do_push;
  logic             do_pop;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                    (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + (AW+1)'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

endmodule

// ----- design/bsw_front.sv -----
module bsw_front (
  input  logic          [2:0]  in_func,
  input  logic          [31:0] in_value,
  output bsw_pkg::cmd_t        cmd
);
  import bsw_pkg::*;

  always_comb begin
    cmd.kind   = K_NOP;
    cmd.nbytes = 3'd0;
    cmd.value  = '0;
    case (in_func)
      FUNC_BYTE: begin
        cmd.kind   = K_FIXED;
        cmd.nbytes = 3'd1;
        cmd.value  = {24'd0, in_value[7:0]};
      end
      FUNC_HALF: begin
        cmd.kind   = K_FIXED;
        cmd.nbytes = 3'd2;
        cmd.value  = {16'd0, in_value[15:0]};
      end
      FUNC_WORD: begin
        cmd.kind   = K_FIXED;
        cmd.nbytes = 3'd4;
        cmd.value  = in_value;
      end
      FUNC_LEB: begin
        cmd.kind   = K_LEB;
        cmd.value  = in_value;
      end
      FUNC_RESTART: begin
        cmd.kind   = K_RESTART;
      end
      default: begin
        cmd.kind   = K_NOP;
      end
    endcase
  end

endmodule

// ----- design/bsw_back.sv -----
module bsw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsw_pkg::cmd_t        cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  logic          [31:0] capacity,
  input  logic                 res_full,
  output logic                 res_push,
  output bsw_pkg::res_t        res
);
  import bsw_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state_r, state_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] val_r, val_nxt;
  logic [2:0]  n_r, n_nxt;
  logic        chk_r, chk_nxt;
  logic [31:0] count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic        step;
  logic        done;
  logic        more;
  logic        room_fixed;

  // room for the whole fixed write, sum kept one bit wider so it cannot wrap
  assign room_fixed = ({1'b0, count_r} + 33'(n_r)) <= {1'b0, capacity};
  assign more       = |val_r[31:7];
  assign step       = (state_r == ST_RUN) && !res_full;
  assign res_push   = step;

  always_comb begin
    res.out_byte   = 8'd0;
    res.byte_valid = 1'b0;
    res.last       = 1'b1;
    res.overflow   = ovf_r;
    done      = 1'b0;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    val_nxt   = val_r;
    n_nxt     = n_r;
    chk_nxt   = chk_r;
    kind_nxt  = kind_r;
    state_nxt = state_r;

    if (step) begin
      case (kind_r)
        K_RESTART: begin
          count_nxt    = '0;
          ovf_nxt      = 1'b0;
          res.overflow = 1'b0;
          done         = 1'b1;
        end
        K_FIXED: begin
          if (!chk_r && (ovf_r || !room_fixed)) begin
            ovf_nxt      = 1'b1;
            res.overflow = 1'b1;
            done         = 1'b1;
          end else begin
            res.out_byte   = val_r[7:0];
            res.byte_valid = 1'b1;
            res.last       = (n_r == 3'd1);
            count_nxt      = count_r + 32'd1;
            val_nxt        = {8'd0, val_r[31:8]};
            n_nxt          = n_r - 3'd1;
            chk_nxt        = 1'b1;
            done           = (n_r == 3'd1);
          end
        end
        K_LEB: begin
          // one byte of room is count + 1 <= capacity
          if (ovf_r || (count_r >= capacity)) begin
            ovf_nxt      = 1'b1;
            res.overflow = 1'b1;
            done         = 1'b1;
          end else begin
            res.out_byte   = {more, val_r[6:0]};
            res.byte_valid = 1'b1;
            res.last       = !more;
            count_nxt      = count_r + 32'd1;
            val_nxt        = {7'd0, val_r[31:7]};
            done           = !more;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    cmd_pop = !cmd_empty && ((state_r == ST_IDLE) || done);

    if (cmd_pop) begin
      kind_nxt  = cmd.kind;
      val_nxt   = cmd.value;
      n_nxt     = cmd.nbytes;
      chk_nxt   = 1'b0;
      state_nxt = ST_RUN;
    end else if (done) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      chk_r   <= 1'b0;
      kind_r  <= K_NOP;
      n_r     <= 3'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      chk_r   <= chk_nxt;
      kind_r  <= kind_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- design/byte_stream_writer_leb128_top.sv -----
// channel   direction  handshake        beat
// input     in         push / full      in_func, in_value
// result    out        empty / pop      out_byte, out_byte_valid, out_last, out_overflow
// config    in         psel / penable   capacity at word 0 (paddr 0)
//
// the back sequencer gives one result beat a cycle while the result queue has room: a byte write gives 1 beat,
// a half 2, a word 4, an leb128 value 1 to 5, any status result 1
// a new command is taken from the command queue in the cycle the last beat goes out
// reset is synchronous; byte count and overflow clear, capacity returns to all ones
// a full result queue stalls the back end only; the front keeps filling its queue
module byte_stream_writer_leb128_top #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic        out_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsw_pkg::*;

  cmd_t        front_cmd;
  cmd_t        back_cmd;
  logic [$bits(cmd_t)-1:0] cmd_q_data;
  logic        cmd_empty;
  logic        cmd_pop;
  res_t        back_res;
  res_t        out_res;
  logic [$bits(res_t)-1:0] res_q_data;
  logic        res_full;
  logic        res_push;
  logic [31:0] capacity_r;
  logic        cap_sel;

  // register index is the word address
  assign cap_sel = (paddr[2] == REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? capacity_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity_r <= pwdata;
    end
  end

  bsw_front u_front (
    .in_func  (in_func),
    .in_value (in_value),
    .cmd      (front_cmd)
  );

  bsw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_q_data),
    .empty     (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_q_data);

  bsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .capacity  (capacity_r),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  bsw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (back_res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_q_data),
    .empty     (empty)
  );

  assign out_res        = res_t'(res_q_data);
  assign out_byte       = out_res.out_byte;
  assign out_byte_valid = out_res.byte_valid;
  assign out_last       = out_res.last;
  assign out_overflow   = out_res.overflow;

endmodule

// ----- verif/tb.sv -----
module tb;
  import bsw_pkg::*;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] value;
  } stream_op_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [2:0]  in_func;
  logic [31:0] in_value;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last;
  logic        out_overflow;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stream_op_t pending_ops[$];
  res_t       stream_q[$];

  // shadow of the writer state
  logic [31:0] cap_model;
  logic [31:0] count_model;
  logic        ovf_model;

  bit holding;
  int in_gap;
  int out_wait;
  bit in_calm;
  bit out_calm;
  int mismatches;

  byte_stream_writer_leb128_top uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_func(in_func), .in_value(in_value),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_last(out_last), .out_overflow(out_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic void append_beat(logic [7:0] b, logic valid, logic fin);
    res_t r;
    r.out_byte = b;
    r.byte_valid = valid;
    r.last = fin;
    r.overflow = ovf_model;
    stream_q.push_back(r);
  endfunction

  // room check without wrap; a failed check makes the flag stick
  function automatic bit has_room(int unsigned n);
    if (ovf_model) return 1'b0;
    if ({1'b0, count_model} + 33'(n) > {1'b0, cap_model}) begin
      ovf_model = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void serialise_fixed(logic [31:0] v, int unsigned n);
    if (!has_room(n)) begin
      append_beat(8'h00, 1'b0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        append_beat(8'(v >> (8 * i)), 1'b1, i + 1 == n);
        count_model++;
      end
    end
  endfunction

  function automatic void serialise_leb(logic [31:0] v);
    logic [7:0] b;
    int k;
    k = 0;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b = b | 8'h80;
      if (!has_room(1)) begin
        append_beat(8'h00, 1'b0, 1'b1);
        return;
      end
      append_beat(b, 1'b1, v == 0);
      count_model++;
      k++;
    end while (v != 0 && k < 5);
  endfunction

  function automatic void serialise(logic [2:0] f, logic [31:0] v);
    case (f)
      FUNC_BYTE: serialise_fixed({24'h0, v[7:0]}, 1);
      FUNC_HALF: serialise_fixed({16'h0, v[15:0]}, 2);
      FUNC_WORD: serialise_fixed(v, 4);
      FUNC_LEB: serialise_leb(v);
      FUNC_RESTART: begin
        count_model = '0;
        ovf_model = 1'b0;
        append_beat(8'h00, 1'b0, 1'b1);
      end
      default: append_beat(8'h00, 1'b0, 1'b1);
    endcase
  endfunction

  // input side: take the beat at the rising edge, drive the next one at the falling edge
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      serialise(in_func, in_value);
      holding = 1'b0;
      in_gap = in_calm ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk) begin
    stream_op_t op;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!holding) begin
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_func <= op.func;
        in_value <= op.value;
        push <= 1'b1;
        holding = 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (stream_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat byte=%02h valid=%b last=%b ovf=%b",
                                out_byte, out_byte_valid, out_last, out_overflow));
      end else begin
        want = stream_q.pop_front();
        if (out_byte !== want.out_byte || out_byte_valid !== want.byte_valid ||
            out_last !== want.last || out_overflow !== want.overflow)
          note_mismatch($sformatf(
            "byte %02h/%02h valid %b/%b last %b/%b ovf %b/%b (expected/actual)",
            want.out_byte, out_byte, want.byte_valid, out_byte_valid,
            want.last, out_last, want.overflow, out_overflow));
      end
      out_wait = out_calm ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic add_op(logic [2:0] f, logic [31:0] v);
    stream_op_t op;
    op.func = f;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  task automatic add_random_ops(int n);
    logic [2:0] f;
    logic [31:0] v;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) f = FUNC_RESTART;
      else if (r < 17) f = 3'($urandom_range(5, 7));
      else if (r < 45) f = FUNC_LEB;
      else f = 3'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: v = $urandom;
        // shorter values spread leb128 lengths over 1 to 5 bytes
        1: v = $urandom >> $urandom_range(0, 31);
        2: v = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0080;
        default: v = $urandom & 32'h0000_7fff;
      endcase
      add_op(f, v);
    end
  endtask

  task automatic wait_idle();
    wait (pending_ops.size() == 0 && !holding && stream_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= v;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_model = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    // read back
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v)
      note_mismatch($sformatf("capacity read %08h, expected %08h", prdata, v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [31:0] cap_pick;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_func = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cap_model = CAPACITY_RESET;
    count_model = '0;
    ovf_model = 1'b0;
    holding = 1'b0;
    in_gap = 0;
    out_wait = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    mismatches = 0;

    // reset capacity: every operation and the field extremes
    add_op(FUNC_BYTE, 32'h0000_0000);
    add_op(FUNC_BYTE, 32'hffff_ffff);
    add_op(FUNC_HALF, 32'h0000_ffff);
    add_op(FUNC_WORD, 32'h89ab_cdef);
    add_op(FUNC_LEB, 32'h0000_0000);
    add_op(FUNC_LEB, 32'h0000_007f);
    add_op(FUNC_LEB, 32'h0000_0080);
    add_op(FUNC_LEB, 32'hffff_ffff);
    add_op(3'd5, 32'h1234_5678);
    add_op(3'd7, 32'hffff_ffff);
    add_op(FUNC_RESTART, 32'h0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // zero capacity: first write fails, then the flag holds until restart
    set_capacity(32'h0);
    add_op(FUNC_BYTE, 32'h0000_00aa);
    add_op(FUNC_LEB, 32'h0000_0080);
    add_op(FUNC_RESTART, 32'h0);
    wait_idle();

    // exact fill, fixed write that does not fit, leb128 cut short
    set_capacity(32'd7);
    add_op(FUNC_HALF, 32'h0000_beef);
    add_op(FUNC_BYTE, 32'h0000_00a5);
    add_op(FUNC_WORD, 32'hdead_beef);
    add_op(FUNC_BYTE, 32'h0000_0011);
    add_op(FUNC_RESTART, 32'h0);
    add_op(FUNC_WORD, 32'h0102_0304);
    add_op(FUNC_LEB, 32'hffff_ffff);
    add_op(FUNC_RESTART, 32'h0);
    add_op(FUNC_HALF, 32'h0000_1234);
    wait_idle();

    // capacity dropped below the bytes already written
    set_capacity(32'd1);
    add_op(FUNC_BYTE, 32'h0000_0055);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cap_pick = 32'hffff_ffff;
        1: cap_pick = $urandom_range(0, 24);
        2: cap_pick = $urandom_range(0, 64);
        3: cap_pick = $urandom;
        4: cap_pick = 32'h0;
        default: cap_pick = 32'hffff_ffff;
      endcase
      in_calm = (ph % 3 == 1);
      out_calm = (ph % 2 == 1);
      set_capacity(cap_pick);
      add_op(FUNC_RESTART, 32'h0);
      add_random_ops(25);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && stream_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
